>>> src/word_bit_stuffer_destuffer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the word bit stuffer / destuffer unit
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef WORD_BIT_STUFFER_DESTUFFER_UNIT_ASSERT_SVH
`define WORD_BIT_STUFFER_DESTUFFER_UNIT_ASSERT_SVH

// Plain property check
`define WBSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define WBSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define WBSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/wbsd_pkg.sv
// ----------------------------------------------------------------------------
// wbsd_pkg
// Constants and the per-item record carried along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package wbsd_pkg;

  // Data word width and ones-run length that triggers a stuffed bit
  localparam int WordBits  = 32;
  localparam int RunLength = 5;
  // Stuffed field width
  localparam int FieldBits = 40;

  // One cell per bit step: the longer of the two loops
  localparam int NumCells = (WordBits > FieldBits) ? WordBits : FieldBits;

  localparam int CntW  = $clog2(NumCells + 1);
  localparam int IdxW  = $clog2(FieldBits);
  localparam int StepW = $clog2(NumCells + 1);
  localparam int RunW  = $clog2(RunLength + 1);

  // Output field widths
  localparam int BitCountW = 6;
  localparam int OutDataW  = 48;
  localparam int InDataW   = 40;

  // Action codes
  localparam logic ActStuff   = 1'b0;
  localparam logic ActDestuff = 1'b1;

  // Keeps only the word bits in stuff mode
  localparam logic [FieldBits-1:0] WordMask =
    (WordBits >= FieldBits) ? {FieldBits{1'b1}}
                            : ((FieldBits'(1) << WordBits) - FieldBits'(1));

  // Item state as it moves from cell to cell
  typedef struct packed {
    logic                 mode;  // ActStuff / ActDestuff
    logic [FieldBits-1:0] src;   // remaining input bits, next bit in [0]
    logic [FieldBits-1:0] acc;   // output bits built so far
    logic [CntW-1:0]      pos;   // stuff: output bits; destuff: data bits
    logic [CntW-1:0]      used;  // destuff: input bits consumed
    logic [StepW-1:0]     step;  // bit steps done
    logic [RunW-1:0]      run;   // current ones run
    logic                 viol;  // destuff: a dropped bit was 1
  } item_t;

endpackage

`default_nettype wire

>>> src/wbsd_cell.sv
// ----------------------------------------------------------------------------
// wbsd_cell
// One bit step of stuffing or destuffing, registered, with its own handshake.
// ----------------------------------------------------------------------------
`default_nettype none

`include "word_bit_stuffer_destuffer_unit_assert.svh"

module wbsd_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire wbsd_pkg::item_t item_i,
  output logic                ready_o,
  output logic                valid_o,
  output wbsd_pkg::item_t     item_o,
  input  wire logic           ready_i
);

  logic            valid_q;
  wbsd_pkg::item_t item_q;
  wbsd_pkg::item_t item_d;

  // Bit step
  always_comb begin
    logic                      b;
    logic [wbsd_pkg::RunW-1:0] run_inc;
    b       = item_i.src[0];
    run_inc = b ? (item_i.run + wbsd_pkg::RunW'(1)) : '0;
    item_d      = item_i;
    item_d.src  = item_i.src >> 1;
    item_d.step = item_i.step + wbsd_pkg::StepW'(1);
    if (item_i.mode == wbsd_pkg::ActStuff) begin
      if (item_i.step < wbsd_pkg::StepW'(wbsd_pkg::WordBits)) begin
        if (item_i.pos < wbsd_pkg::CntW'(wbsd_pkg::FieldBits)) begin
          item_d.acc[item_i.pos[wbsd_pkg::IdxW-1:0]] = b;
          item_d.pos = item_i.pos + wbsd_pkg::CntW'(1);
        end
        item_d.run = run_inc;
        // run closed: skip one position for the inserted zero
        if (run_inc >= wbsd_pkg::RunW'(wbsd_pkg::RunLength)) begin
          if (item_d.pos < wbsd_pkg::CntW'(wbsd_pkg::FieldBits)) begin
            item_d.pos = item_d.pos + wbsd_pkg::CntW'(1);
          end
          item_d.run = '0;
        end
      end
    end else begin
      // done once the word is complete and no stuffed bit is pending
      if (!(item_i.pos >= wbsd_pkg::CntW'(wbsd_pkg::WordBits) &&
            item_i.run < wbsd_pkg::RunW'(wbsd_pkg::RunLength))) begin
        item_d.used = item_i.used + wbsd_pkg::CntW'(1);
        if (item_i.run >= wbsd_pkg::RunW'(wbsd_pkg::RunLength)) begin
          // stuffed bit: drop it
          item_d.viol = item_i.viol | b;
          item_d.run  = '0;
        end else begin
          if (item_i.pos < wbsd_pkg::CntW'(wbsd_pkg::FieldBits)) begin
            item_d.acc[item_i.pos[wbsd_pkg::IdxW-1:0]] = b;
          end
          item_d.pos = item_i.pos + wbsd_pkg::CntW'(1);
          item_d.run = run_inc;
        end
      end
    end
  end

  // Move when empty or when the next cell takes our item
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

  // Checks
  `WBSD_ASSERT_NXT(a_hold_on_stall, valid_q && !ready_i, valid_q && $stable(item_q),
                   "cell lost or changed a stalled item")
  `WBSD_ASSERT_IMP(a_pos_range, valid_q, item_q.pos <= wbsd_pkg::CntW'(wbsd_pkg::NumCells),
                   "bit position out of range")
  `WBSD_ASSERT_IMP(a_run_range, valid_q, item_q.run <= wbsd_pkg::RunW'(wbsd_pkg::RunLength),
                   "ones run exceeds run length")
  `WBSD_ASSERT_IMP(a_step_nonzero, valid_q, item_q.step != '0,
                   "registered item did not advance its step")

endmodule

`default_nettype wire

>>> src/word_bit_stuffer_destuffer_unit.sv
// ----------------------------------------------------------------------------
// word_bit_stuffer_destuffer_unit
// HDLC-style zero-bit insertion and removal of one chunk per item,
// built as a chain of one-bit cells.
// ----------------------------------------------------------------------------
//  Channel   Dir  tdata (LSB up)                                  tuser
//  s_axis    in   data_in[39:0]                                   action
//  m_axis    out  data_out[39:0], bit_count[45:40], viol[46], 0   -
//
//  One item per cycle unless the output stalls; each item passes the chain,
//  one cell per bit step (cell count is the longer of word and field widths).
//  The last cell register is the output register.
//  Reset clears all cell valid bits; payload registers are not reset.
//  A stalled output holds its item; empty cells upstream still fill.
// ----------------------------------------------------------------------------
`default_nettype none

module word_bit_stuffer_destuffer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,   // data_in[39:0]
  input  wire logic        s_axis_tuser_i,   // action
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o    // data_out[39:0], bit_count[45:40],
                                             // stuff_violation[46], zero[47]
);

  logic            valid_w [wbsd_pkg::NumCells+1];
  logic            ready_w [wbsd_pkg::NumCells+1];
  wbsd_pkg::item_t item_w  [wbsd_pkg::NumCells+1];

  // Fresh item at the chain head
  always_comb begin
    item_w[0]      = '0;
    item_w[0].mode = s_axis_tuser_i;
    item_w[0].src  = (s_axis_tuser_i == wbsd_pkg::ActDestuff)
                   ? s_axis_tdata_i[wbsd_pkg::FieldBits-1:0]
                   : (s_axis_tdata_i[wbsd_pkg::FieldBits-1:0] & wbsd_pkg::WordMask);
  end
  assign valid_w[0]      = s_axis_tvalid_i;
  assign s_axis_tready_o = ready_w[0];

  // Cell chain
  for (genvar k = 0; k < wbsd_pkg::NumCells; k++) begin : g_cell
    wbsd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[k]),
      .item_i  (item_w[k]),
      .ready_o (ready_w[k]),
      .valid_o (valid_w[k+1]),
      .item_o  (item_w[k+1]),
      .ready_i (ready_w[k+1])
    );
  end

  // Result packing
  assign ready_w[wbsd_pkg::NumCells] = m_axis_tready_i;
  assign m_axis_tvalid_o = valid_w[wbsd_pkg::NumCells];

  always_comb begin
    logic [wbsd_pkg::CntW-1:0] cnt;
    cnt = (item_w[wbsd_pkg::NumCells].mode == wbsd_pkg::ActDestuff)
        ? item_w[wbsd_pkg::NumCells].used : item_w[wbsd_pkg::NumCells].pos;
    m_axis_tdata_o        = '0;
    m_axis_tdata_o[39:0]  = item_w[wbsd_pkg::NumCells].acc;
    m_axis_tdata_o[45:40] = wbsd_pkg::BitCountW'(cnt);
    m_axis_tdata_o[46]    = item_w[wbsd_pkg::NumCells].viol;
  end

endmodule

`default_nettype wire

>>> test/word_bit_stuffer_destuffer_unit_tb.sv
// ----------------------------------------------------------------------------
// word_bit_stuffer_destuffer_unit_tb
// Drives stuff and destuff items through the stream input and checks every
// output item against a local zero-bit insertion / removal predictor or, for
// typed directed rows, against written-out results. A short directed table
// comes first, then random words, stuffed streams with random tails and
// corrupted stuffed streams. Random gaps and stalls are used on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module word_bit_stuffer_destuffer_unit_tb;

  localparam int RandItems   = 1000;
  localparam int DrainCycles = 80;   // chain is 40 cells deep
  localparam int MaxPrinted  = 40;

  // One output item as the predictor sees it
  typedef struct packed {
    logic [39:0] data;
    logic [5:0]  count;
    logic        viol;
  } chunk_result_t;

  // Directed row: typed marks rows whose result is written out here
  typedef struct packed {
    logic        action;
    logic [39:0] data;
    logic        typed;
    logic [39:0] want_data;
    logic [5:0]  want_count;
    logic        want_viol;
  } stim_row_t;

  localparam int NumRows = 21;
  localparam stim_row_t DirRows [NumRows] = '{
    // all zeros, and bits above the word ignored
    '{wbsd_pkg::ActStuff,   40'h00_0000_0000, 1'b1, 40'h00_0000_0000, 6'd32, 1'b0},
    '{wbsd_pkg::ActStuff,   40'hFF_0000_0000, 1'b1, 40'h00_0000_0000, 6'd32, 1'b0},
    // longest stuffed output
    '{wbsd_pkg::ActStuff,   40'h00_FFFF_FFFF, 1'b0, 40'h0, 6'd0, 1'b0},
    '{wbsd_pkg::ActStuff,   40'hFF_FFFF_FFFF, 1'b0, 40'h0, 6'd0, 1'b0},
    // run at the start, run closing at the last bit
    '{wbsd_pkg::ActStuff,   40'h00_0000_001F, 1'b0, 40'h0, 6'd0, 1'b0},
    '{wbsd_pkg::ActStuff,   40'h00_F800_0000, 1'b0, 40'h0, 6'd0, 1'b0},
    // four ones never trigger an insertion
    '{wbsd_pkg::ActStuff,   40'h00_0000_000F, 1'b1, 40'h00_0000_000F, 6'd32, 1'b0},
    '{wbsd_pkg::ActStuff,   40'h00_AAAA_AAAA, 1'b1, 40'h00_AAAA_AAAA, 6'd32, 1'b0},
    '{wbsd_pkg::ActStuff,   40'h00_0000_03FF, 1'b0, 40'h0, 6'd0, 1'b0},
    '{wbsd_pkg::ActStuff,   40'h00_7BDE_F7BD, 1'b0, 40'h0, 6'd0, 1'b0},
    // destuff extremes; all ones drops a one after every run
    '{wbsd_pkg::ActDestuff, 40'h00_0000_0000, 1'b1, 40'h00_0000_0000, 6'd32, 1'b0},
    '{wbsd_pkg::ActDestuff, 40'hFF_FFFF_FFFF, 1'b1, 40'h00_FFFF_FFFF, 6'd38, 1'b1},
    // dropped zero, then dropped one
    '{wbsd_pkg::ActDestuff, 40'h00_0000_001F, 1'b1, 40'h00_0000_001F, 6'd33, 1'b0},
    '{wbsd_pkg::ActDestuff, 40'h00_0000_003F, 1'b1, 40'h00_0000_001F, 6'd33, 1'b1},
    // bits past the consumed count are ignored
    '{wbsd_pkg::ActDestuff, 40'h01_0000_0000, 1'b1, 40'h00_0000_0000, 6'd32, 1'b0},
    '{wbsd_pkg::ActDestuff, 40'hAA_AAAA_AAAA, 1'b1, 40'h00_AAAA_AAAA, 6'd32, 1'b0},
    // run closes on the last data bit: stuffed bit still consumed
    '{wbsd_pkg::ActDestuff, 40'h00_F800_0000, 1'b1, 40'h00_F800_0000, 6'd33, 1'b0},
    '{wbsd_pkg::ActDestuff, 40'h01_F800_0000, 1'b1, 40'h00_F800_0000, 6'd33, 1'b1},
    '{wbsd_pkg::ActDestuff, 40'hFF_FFFF_FFC0, 1'b0, 40'h0, 6'd0, 1'b0},
    '{wbsd_pkg::ActDestuff, 40'h3E_FBEF_BEFB, 1'b0, 40'h0, 6'd0, 1'b0},
    '{wbsd_pkg::ActDestuff, 40'h7D_F7DF_7DF7, 1'b0, 40'h0, 6'd0, 1'b0}
  };

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i  = '0;    // data_in[39:0]
  logic        s_axis_tuser_i  = 1'b0;  // action
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;          // data_out[39:0], bit_count[45:40],
                                        // stuff_violation[46], zero[47]

  chunk_result_t pending_results[$];
  int            errors    = 0;
  int            cyc_count = 0;
  int            stall_left = 0;

  word_bit_stuffer_destuffer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #4ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Zero insertion after every run of ones, LSB first
  function automatic chunk_result_t stuff_word(logic [39:0] word);
    chunk_result_t r;
    int            pos;
    int            run;
    logic          b;
    r   = '0;
    pos = 0;
    run = 0;
    for (int i = 0; i < wbsd_pkg::WordBits; i++) begin
      b = (i < wbsd_pkg::FieldBits) ? word[i] : 1'b0;
      if (pos < wbsd_pkg::FieldBits) begin
        r.data[pos] = b;
        pos++;
      end
      run = b ? run + 1 : 0;
      if (run >= wbsd_pkg::RunLength) begin
        if (pos < wbsd_pkg::FieldBits) pos++;  // inserted bit is already zero
        run = 0;
      end
    end
    r.count = pos[5:0];
    return r;
  endfunction

  // Drop the bit after every run of ones until the word is complete
  function automatic chunk_result_t destuff_field(logic [39:0] field);
    chunk_result_t r;
    int            got;
    int            run;
    int            used;
    logic          b;
    r    = '0;
    got  = 0;
    run  = 0;
    used = 0;
    for (int i = 0; i < wbsd_pkg::FieldBits; i++) begin
      if (got >= wbsd_pkg::WordBits && run < wbsd_pkg::RunLength) break;
      b = field[i];
      used++;
      if (run >= wbsd_pkg::RunLength) begin
        r.viol = r.viol | b;
        run    = 0;
      end else begin
        if (got < wbsd_pkg::FieldBits) r.data[got] = b;
        got++;
        run = b ? run + 1 : 0;
      end
    end
    r.count = used[5:0];
    return r;
  endfunction

  function automatic chunk_result_t predict_chunk(logic action, logic [39:0] data);
    return (action == wbsd_pkg::ActStuff) ? stuff_word(data) : destuff_field(data);
  endfunction

  // Mostly no gap, some short, a few long; none in calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (cyc_count % 1024 >= 768) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Uniform, or biased toward long runs of ones
  function automatic logic [39:0] rand_field();
    logic [39:0] a;
    logic [39:0] b;
    logic [39:0] c;
    a = 40'({$urandom, $urandom});
    b = 40'({$urandom, $urandom});
    c = 40'({$urandom, $urandom});
    case ($urandom_range(0, 2))
      0:       return a;
      1:       return a | b;
      default: return a | b | c;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (errors < MaxPrinted)
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // Present one item and hold it until taken
  task automatic send_item(logic action, logic [39:0] data, chunk_result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tuser_i  <= action;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(want);
  endtask

  always @(posedge clk_i) cyc_count <= cyc_count + 1;

  // Output side: random stalls and compare
  always @(posedge clk_i) begin : out_side
    chunk_result_t want;
    int            g;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected item", 64'(m_axis_tdata_o), 64'(0));
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata_o[39:0] !== want.data)
            report_mismatch("data_out", 64'(m_axis_tdata_o[39:0]), 64'(want.data));
          if (m_axis_tdata_o[45:40] !== want.count)
            report_mismatch("bit_count", 64'(m_axis_tdata_o[45:40]), 64'(want.count));
          if (m_axis_tdata_o[46] !== want.viol)
            report_mismatch("stuff_violation", 64'(m_axis_tdata_o[46]), 64'(want.viol));
          if (m_axis_tdata_o[47] !== 1'b0)
            report_mismatch("pad bit", 64'(m_axis_tdata_o[47]), 64'(0));
        end
      end
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left      <= stall_left - 1;
      end else begin
        g = pick_gap();
        m_axis_tready_i <= (g == 0);
        if (g > 0) stall_left <= g - 1;
      end
    end
  end

  // Reset, directed table, random items, drain
  initial begin : stimulus
    chunk_result_t want;
    chunk_result_t s;
    logic [39:0]   field;
    logic [39:0]   tail;
    int            kind;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < NumRows; k++) begin
      if (DirRows[k].typed)
        want = '{DirRows[k].want_data, DirRows[k].want_count, DirRows[k].want_viol};
      else
        want = predict_chunk(DirRows[k].action, DirRows[k].data);
      send_item(DirRows[k].action, DirRows[k].data, want);
    end

    for (int n = 0; n < RandItems; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        // well-formed stuffed stream with a random tail, sometimes one bit flipped
        s     = stuff_word(rand_field());
        tail  = 40'({$urandom, $urandom});
        field = s.data | (tail << s.count);
        if (kind < 12) field = field ^ (40'd1 << $urandom_range(0, s.count - 1));
        send_item(wbsd_pkg::ActDestuff, field, destuff_field(field));
      end else if (kind < 75) begin
        field = rand_field();
        send_item(wbsd_pkg::ActStuff, field, stuff_word(field));
      end else begin
        field = rand_field();
        send_item(wbsd_pkg::ActDestuff, field, destuff_field(field));
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
